// ===== src/sphere_box_overlap_test_defines.svh =====
// Assertion macros shared by the sphere/box overlap test RTL.
`ifndef SPHERE_BOX_OVERLAP_TEST_DEFINES_SVH
`define SPHERE_BOX_OVERLAP_TEST_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define SBO_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define SBO_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/sbo_pkg.sv =====
// Package for the sphere/box overlap test: shape codes, defaults, queue flags.
package sbo_pkg;

	localparam int COORD_BITS_DEF = 32;
	localparam int QUEUE_DEPTH    = 4;

	localparam logic [1:0] SHAPE_NONE   = 2'd0;
	localparam logic [1:0] SHAPE_SPHERE = 2'd1;
	localparam logic [1:0] SHAPE_BOX    = 2'd2;

	// How the back end settles an item
	typedef struct packed {
		logic use_sq;     // compare sum of squares against rhs squared
		logic fixed_hit;  // result when use_sq is low
	} sbo_flags_t;

	localparam int FLAGS_BITS = $bits(sbo_flags_t);

endpackage

// ===== src/sbo_channels.sv =====
// Channel interfaces: shape pair items in, hit items out.
interface sbo_pair_if #(
	parameter int COORD_BITS = sbo_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   first_shape;
	logic [1:0]                   second_shape;
	logic signed [COORD_BITS-1:0] offset_x;
	logic signed [COORD_BITS-1:0] offset_y;
	logic signed [COORD_BITS-1:0] offset_z;
	logic [COORD_BITS-2:0]        first_extent_x;
	logic [COORD_BITS-2:0]        first_extent_y;
	logic [COORD_BITS-2:0]        first_extent_z;
	logic [COORD_BITS-2:0]        second_extent_x;
	logic [COORD_BITS-2:0]        second_extent_y;
	logic [COORD_BITS-2:0]        second_extent_z;

	modport source (
		output valid, first_shape, second_shape, offset_x, offset_y, offset_z,
		       first_extent_x, first_extent_y, first_extent_z,
		       second_extent_x, second_extent_y, second_extent_z,
		input  ready
	);
	modport sink (
		input  valid, first_shape, second_shape, offset_x, offset_y, offset_z,
		       first_extent_x, first_extent_y, first_extent_z,
		       second_extent_x, second_extent_y, second_extent_z,
		output ready
	);
endinterface

interface sbo_hit_if;
	logic valid;
	logic ready;
	logic hit;

	modport source (output valid, hit, input ready);
	modport sink (input valid, hit, output ready);
endinterface

// ===== src/sbo_front.sv =====
// Front end: takes pair items, works out magnitudes, clamps and the box/box verdict.
module sbo_front #(
	parameter int COORD_BITS = sbo_pkg::COORD_BITS_DEF,
	parameter int QW         = sbo_pkg::FLAGS_BITS + 4 * COORD_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	sbo_pair_if.sink      pair,
	output logic          push,
	input  logic          push_ready,
	output logic [QW-1:0] push_data
);
	import sbo_pkg::*;

	localparam int C = COORD_BITS;

	logic                 valid_s1;
	logic [1:0]           shape1_s1, shape2_s1;
	logic [2:0][C-1:0]    mag_s1;
	logic [2:0][C-2:0]    e1_s1, e2_s1;

	logic [2:0][C-1:0]    off_c, mag_c;
	logic [2:0][C-2:0]    e1_c, e2_c;
	logic [2:0][C-1:0]    esum, box, res, vals;
	logic [C-2:0]         radius;
	logic [C-1:0]         rhs;
	logic                 bb_ok, first_box, is_ss, is_bb, is_sb;
	sbo_flags_t           flags;

	assign pair.ready = !valid_s1 || push_ready;
	assign push       = valid_s1;

	// Magnitudes; the most negative offset maps onto 2^(C-1) exactly
	always_comb begin
		off_c = {pair.offset_z, pair.offset_y, pair.offset_x};
		e1_c  = {pair.first_extent_z, pair.first_extent_y, pair.first_extent_x};
		e2_c  = {pair.second_extent_z, pair.second_extent_y, pair.second_extent_x};
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = off_c[i][C-1] ? (~off_c[i] + 1'b1) : off_c[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pair.ready) begin
			valid_s1 <= pair.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pair.ready && pair.valid) begin
			shape1_s1 <= pair.first_shape;
			shape2_s1 <= pair.second_shape;
			mag_s1    <= mag_c;
			e1_s1     <= e1_c;
			e2_s1     <= e2_c;
		end
	end

	always_comb begin
		first_box = (shape1_s1 == SHAPE_BOX);
		is_ss = (shape1_s1 == SHAPE_SPHERE) && (shape2_s1 == SHAPE_SPHERE);
		is_bb = (shape1_s1 == SHAPE_BOX) && (shape2_s1 == SHAPE_BOX);
		is_sb = ((shape1_s1 == SHAPE_SPHERE) && (shape2_s1 == SHAPE_BOX)) ||
		        ((shape1_s1 == SHAPE_BOX) && (shape2_s1 == SHAPE_SPHERE));
		radius = first_box ? e2_s1[0] : e1_s1[0];
		bb_ok  = 1'b1;
		for (int i = 0; i < 3; i++) begin
			esum[i] = {1'b0, e1_s1[i]} + {1'b0, e2_s1[i]};
			if (mag_s1[i] > esum[i]) begin
				bb_ok = 1'b0;
			end
			// clamp onto the box with this axis's own extent
			box[i] = first_box ? {1'b0, e1_s1[i]} : {1'b0, e2_s1[i]};
			res[i] = (mag_s1[i] > box[i]) ? (mag_s1[i] - box[i]) : '0;
		end
		vals            = is_ss ? mag_s1 : res;
		rhs             = is_ss ? esum[0] : {1'b0, radius};
		flags.use_sq    = is_ss || is_sb;
		flags.fixed_hit = is_bb && bb_ok;
		push_data       = {flags, rhs, vals};
	end

endmodule

// ===== src/sbo_queue.sv =====
// Short item queue between front and back ends.
`include "sphere_box_overlap_test_defines.svh"

module sbo_queue #(
	parameter int W     = 8,
	parameter int DEPTH = sbo_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop,
	output logic [W-1:0] pop_data
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	`SBO_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "queue count past depth")
	`SBO_ASSERT_NEXT(a_count_up, do_push && !do_pop, count_q == $past(count_q) + 1'b1, "queue count missed a push")
	`SBO_ASSERT_NEXT(a_count_down, do_pop && !do_push, count_q == $past(count_q) - 1'b1, "queue count missed a pop")

endmodule

// ===== src/sbo_back.sv =====
// Back end: split squaring pipeline, sum of squares, compare, output register.
`include "sphere_box_overlap_test_defines.svh"

module sbo_back #(
	parameter int COORD_BITS = sbo_pkg::COORD_BITS_DEF,
	parameter int QW         = sbo_pkg::FLAGS_BITS + 4 * COORD_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop,
	input  logic [QW-1:0] pop_data,
	sbo_hit_if.source     result
);
	import sbo_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int H  = (C + 1) / 2;
	localparam int L  = C - H;
	localparam int SW = 2 * C;
	localparam int TW = 2 * C + 2;

	logic                  adv;
	logic [3:0][C-1:0]     val;      // three axis values, then rhs
	sbo_flags_t            flags_c;
	logic [3:0][2*H-1:0]   p00_c;
	logic [3:0][H+L-1:0]   p01_c;
	logic [3:0][2*L-1:0]   p11_c;
	logic [3:0][SW-1:0]    sq_c;

	logic                  valid_s1, valid_s2, valid_s3, out_valid_q;
	sbo_flags_t            flags_s1, flags_s2, flags_s3;
	logic [3:0][2*H-1:0]   p00_s1;
	logic [3:0][H+L-1:0]   p01_s1;
	logic [3:0][2*L-1:0]   p11_s1;
	logic [3:0][SW-1:0]    sq_s2;
	logic [TW-1:0]         sum_s3;
	logic [SW-1:0]         rhs_sq_s3;
	logic                  hit_q;

	// Whole pipe moves together; it stops only while the output item waits
	assign adv          = !out_valid_q || result.ready;
	assign pop          = adv;
	assign result.valid = out_valid_q;
	assign result.hit   = hit_q;

	always_comb begin
		val     = pop_data[4*C-1:0];
		flags_c = pop_data[QW-1 -: FLAGS_BITS];
		for (int i = 0; i < 4; i++) begin
			p00_c[i] = {{H{1'b0}}, val[i][H-1:0]} * {{H{1'b0}}, val[i][H-1:0]};
			p01_c[i] = {{L{1'b0}}, val[i][H-1:0]} * {{H{1'b0}}, val[i][C-1:H]};
			p11_c[i] = {{L{1'b0}}, val[i][C-1:H]} * {{L{1'b0}}, val[i][C-1:H]};
		end
	end

	// v^2 = hi^2 << 2H + 2*lo*hi << H + lo^2; hi^2 and lo^2 do not overlap
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sq_c[i] = {p11_s1[i], p00_s1[i]} +
			          ({{(SW-H-L){1'b0}}, p01_s1[i]} << (H + 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= pop_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flags_s1  <= flags_c;
			p00_s1    <= p00_c;
			p01_s1    <= p01_c;
			p11_s1    <= p11_c;
			flags_s2  <= flags_s1;
			sq_s2     <= sq_c;
			flags_s3  <= flags_s2;
			sum_s3    <= {2'b00, sq_s2[0]} + {2'b00, sq_s2[1]} + {2'b00, sq_s2[2]};
			rhs_sq_s3 <= sq_s2[3];
			hit_q     <= flags_s3.use_sq ? (sum_s3 <= {2'b00, rhs_sq_s3})
			                             : flags_s3.fixed_hit;
		end
	end

	`SBO_ASSERT_NEXT(a_last_stage_lands, adv && valid_s3, out_valid_q, "finished item not presented")
	`SBO_ASSERT_NEXT(a_pipe_frozen, !adv, $stable(valid_s3) && $stable(valid_s1), "pipe moved during stall")
	`SBO_ASSERT_NEXT(a_pop_enters, pop && pop_valid, valid_s1, "popped item lost")

endmodule

// ===== src/sphere_box_overlap_test.sv =====
// Top level of the sphere/box narrow-phase overlap test.
// Takes one shape pair per clock while the output is not stalled and returns one hit item
// per pair, in order. A pair gives two shape codes (none, sphere, box; the unused code
// counts as none), the offset of the second centre from the first as signed fixed point,
// and each shape's half extents (a sphere's radius is its x extent). Any pair with a none
// shape gives no hit; sphere/sphere compares squared distance with the squared radius
// sum, box/box does a per-axis separation test, and sphere/box clamps the offset onto the
// box with each axis's own extent and compares the squared residual with the squared
// radius. Touching is a hit. All products are exact, so nothing rounds and nothing
// overflows. Throughput is one item per cycle while the output is not stalled. A hit
// passes through the front register, then one queue slot and four back-end stages; the
// squaring pipeline splits each square into half-width partial products. A four-entry
// queue sits between front and back end, so the input stays ready while the output stalls,
// until the queue fills.
module sphere_box_overlap_test #(
	parameter int COORD_BITS = sbo_pkg::COORD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sbo_pair_if.sink  pair,
	sbo_hit_if.source result
);
	import sbo_pkg::*;

	// queue entry: flags, rhs, three axis values
	localparam int QW = FLAGS_BITS + 4 * COORD_BITS;

	logic          push, push_ready, pop_valid, pop;
	logic [QW-1:0] push_data, pop_data;

	// Front: magnitudes, clamping, box/box verdict, classification
	sbo_front #(
		.COORD_BITS (COORD_BITS),
		.QW         (QW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair       (pair),
		.push       (push),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// Decoupling queue: each side stalls on its own
	sbo_queue #(
		.W     (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_data   (pop_data)
	);

	// Back: squares, sum, final compare and output register
	sbo_back #(
		.COORD_BITS (COORD_BITS),
		.QW         (QW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_data  (pop_data),
		.result    (result)
	);

endmodule
